// ----- design/soph_pkg.sv -----
package soph_pkg;

    localparam int MAX_SLICES       = 256;
    localparam int MAX_CHANNELS     = 8;
    localparam int COUNT_WIDTH      = 32;
    localparam int CHANNEL_ID_WIDTH = 8;

    localparam int CELLS   = MAX_SLICES * MAX_CHANNELS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int SLOT_W  = $clog2(MAX_CHANNELS);
    localparam int WORD_W  = 3 * COUNT_WIDTH;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_ROUTE    = 3'd1;
    localparam status_t ST_NO_AXIS  = 3'd2;
    localparam status_t ST_PRESENCE = 3'd3;
    localparam status_t ST_RANGE    = 3'd4;
    localparam status_t ST_IDENTITY = 3'd5;
    localparam status_t ST_CHANNEL  = 3'd6;
    localparam status_t ST_OVERFLOW = 3'd7;

    localparam logic [1:0] MODE_P      = 2'd0;
    localparam logic [1:0] MODE_PR     = 2'd1;
    localparam logic [1:0] MODE_PRD    = 2'd2;
    localparam logic [1:0] MODE_NESTED = 2'd3;

    localparam logic [2:0] REG_ROUTE_MODE    = 3'd0;
    localparam logic [2:0] REG_KT_AXIS_EN    = 3'd1;
    localparam logic [2:0] REG_MT_AXIS_EN    = 3'd2;
    localparam logic [2:0] REG_KT_SLICE_TOT  = 3'd3;
    localparam logic [2:0] REG_MT_SLICE_TOT  = 3'd4;
    localparam logic [2:0] REG_CHANNEL_TOT   = 3'd5;
    localparam logic [2:0] REG_CHANNEL_TABLE = 3'd6;

    typedef struct packed {
        logic [7:0] flat_slice;
        logic       kt_present;
        logic [7:0] kt_slice;
        logic       mt_present;
        logic [7:0] mt_slice;
        logic [2:0] channel_slot;
        logic [7:0] channel_code;
        logic       route_p;
        logic       route_pr;
        logic       route_prd;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] count_p;
        logic [31:0] count_pr;
        logic [31:0] count_prd;
    } result_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic [1:0]  route_mode;
        logic        kt_axis_enabled;
        logic        mt_axis_enabled;
        logic [8:0]  kt_slice_total;
        logic [8:0]  mt_slice_total;
        logic [3:0]  channel_total;
        logic [63:0] channel_id_table;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        route_mode:       2'd0,
        kt_axis_enabled:  1'b1,
        mt_axis_enabled:  1'b0,
        kt_slice_total:   9'd16,
        mt_slice_total:   9'd1,
        channel_total:    4'd8,
        channel_id_table: 64'd0
    };

endpackage

// ----- design/soph_if.sv -----
interface soph_item_if;
    logic          valid;
    logic          ready;
    soph_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface soph_result_if;
    logic            valid;
    logic            ready;
    soph_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface soph_cfg_if;
    logic               valid;
    logic               ready;
    soph_pkg::cfg_write_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/sliced_origin_pair_histogram_core.sv -----
// Histogram of P, PR and PRD counters per slice entry and channel slot, held
// side by side in one counter memory of 2048 words with a single port each way.
// After reset the block first clears that memory, one word a cycle; items
// are taken only after that, configuration writes at any time (the
// configuration port is always ready). The cell is read when an item is
// accepted; once the result register is free the busy state finishes the
// item and writes the cell back unless the check fails or it would overflow.
// No new item is accepted until then. The result register lets a new item
// in while the previous result still waits to be taken.
module sliced_origin_pair_histogram_core (
    input  logic               clk,
    input  logic               rst_n,
    soph_item_if.sink          item,
    soph_result_if.source      result,
    soph_cfg_if.sink           cfg
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_BUSY  = 2'd2;

    localparam int CW = soph_pkg::COUNT_WIDTH;

    logic [1:0]                  state_reg, state_next;
    logic [soph_pkg::CELL_AW-1:0] clr_reg, clr_next;
    soph_pkg::cfg_regs_t         cfg_reg, cfg_next;
    soph_pkg::item_t             item_reg;
    logic                        res_valid_reg, res_valid_next;
    soph_pkg::result_t           res_reg;

    soph_pkg::status_t           chk_status;
    logic                        accept;
    logic                        out_free;
    logic                        finish;

    logic                        ram_we;
    logic [soph_pkg::CELL_AW-1:0] ram_waddr;
    logic [soph_pkg::CELL_AW-1:0] ram_raddr;
    logic [soph_pkg::WORD_W-1:0]  ram_wdata;
    logic [soph_pkg::WORD_W-1:0]  ram_rdata;

    logic [CW-1:0]               cur_p, cur_pr, cur_prd;
    logic [CW-1:0]               new_p, new_pr, new_prd;
    logic                        ovf;
    logic                        do_write;
    soph_pkg::result_t           res_next;

    assign accept   = item.valid && item.ready;
    assign out_free = !res_valid_reg || result.ready;
    assign finish   = (state_reg == S_BUSY) && out_free;

    assign item.ready   = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    soph_check u_check (
        .item   (item_reg),
        .cfg    (cfg_reg),
        .status (chk_status)
    );

    soph_ram #(
        .WIDTH (soph_pkg::WORD_W),
        .DEPTH (soph_pkg::CELLS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = soph_pkg::CELL_AW'({item.data.flat_slice,
                                           item.data.channel_slot[soph_pkg::SLOT_W-1:0]});

    // read-modify-write of the addressed cell
    always_comb
    begin
        cur_p   = ram_rdata[CW-1:0];
        cur_pr  = ram_rdata[2*CW-1:CW];
        cur_prd = ram_rdata[3*CW-1:2*CW];
        ovf     = (item_reg.route_p && (cur_p == '1)) ||
                  (item_reg.route_pr && (cur_pr == '1)) ||
                  (item_reg.route_prd && (cur_prd == '1));
        new_p   = cur_p + CW'(item_reg.route_p);
        new_pr  = cur_pr + CW'(item_reg.route_pr);
        new_prd = cur_prd + CW'(item_reg.route_prd);
        do_write = finish && (chk_status == soph_pkg::ST_OK) && !ovf;

        res_next = '0;
        if (chk_status != soph_pkg::ST_OK)
        begin
            res_next.status = chk_status;
        end
        else if (ovf)
        begin
            res_next.status    = soph_pkg::ST_OVERFLOW;
            res_next.count_p   = 32'(cur_p);
            res_next.count_pr  = 32'(cur_pr);
            res_next.count_prd = 32'(cur_prd);
        end
        else
        begin
            res_next.status    = soph_pkg::ST_OK;
            res_next.count_p   = 32'(new_p);
            res_next.count_pr  = 32'(new_pr);
            res_next.count_prd = 32'(new_prd);
        end
    end

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = do_write;
            ram_waddr = soph_pkg::CELL_AW'({item_reg.flat_slice,
                                            item_reg.channel_slot[soph_pkg::SLOT_W-1:0]});
            ram_wdata = {new_prd, new_pr, new_p};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == soph_pkg::CELL_AW'(soph_pkg::CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (finish)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.data.index)
                soph_pkg::REG_ROUTE_MODE:    cfg_next.route_mode       = cfg.data.value[1:0];
                soph_pkg::REG_KT_AXIS_EN:    cfg_next.kt_axis_enabled  = cfg.data.value[0];
                soph_pkg::REG_MT_AXIS_EN:    cfg_next.mt_axis_enabled  = cfg.data.value[0];
                soph_pkg::REG_KT_SLICE_TOT:  cfg_next.kt_slice_total   = cfg.data.value[8:0];
                soph_pkg::REG_MT_SLICE_TOT:  cfg_next.mt_slice_total   = cfg.data.value[8:0];
                soph_pkg::REG_CHANNEL_TOT:   cfg_next.channel_total    = cfg.data.value[3:0];
                soph_pkg::REG_CHANNEL_TABLE: cfg_next.channel_id_table = cfg.data.value;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cfg_reg       <= soph_pkg::CFG_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cfg_reg       <= cfg_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item.data;
        end
        if (finish)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- design/soph_ram.sv -----
module soph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/soph_check.sv -----
module soph_check (
    input  soph_pkg::item_t     item,
    input  soph_pkg::cfg_regs_t cfg,
    output soph_pkg::status_t   status
);

    logic        conflict;
    logic [17:0] prod;
    logic [17:0] total;
    logic [17:0] total_sat;
    logic        in_range;
    logic [17:0] recomb;
    logic        ident_ok;
    logic [3:0]  chans;
    logic        slot_ok;
    logic        code_ok;

    always_comb
    begin
        case (cfg.route_mode)
            soph_pkg::MODE_P:   conflict = item.route_pr || item.route_prd;
            soph_pkg::MODE_PR:  conflict = item.route_p || item.route_prd;
            soph_pkg::MODE_PRD: conflict = item.route_p || item.route_pr;
            default:            conflict = (item.route_p && !item.route_pr) ||
                                           (item.route_pr && !item.route_prd);
        endcase
    end

    // entry count, saturated
    always_comb
    begin
        prod = 18'(cfg.kt_slice_total) * 18'(cfg.mt_slice_total);
        if (cfg.kt_axis_enabled && cfg.mt_axis_enabled)
        begin
            total = prod;
        end
        else if (cfg.kt_axis_enabled)
        begin
            total = 18'(cfg.kt_slice_total);
        end
        else
        begin
            total = 18'(cfg.mt_slice_total);
        end
        total_sat = (total > 18'(soph_pkg::MAX_SLICES)) ? 18'(soph_pkg::MAX_SLICES) : total;
        in_range  = 18'(item.flat_slice) < total_sat;
    end

    // kt*m + mt == flat with mt < m is the same as the div/mod split
    always_comb
    begin
        recomb = 18'(item.kt_slice) * 18'(cfg.mt_slice_total) + 18'(item.mt_slice);
        if (cfg.kt_axis_enabled && cfg.mt_axis_enabled)
        begin
            ident_ok = (recomb == 18'(item.flat_slice)) &&
                       (9'(item.mt_slice) < cfg.mt_slice_total);
        end
        else if (cfg.kt_axis_enabled)
        begin
            ident_ok = item.kt_slice == item.flat_slice;
        end
        else
        begin
            ident_ok = item.mt_slice == item.flat_slice;
        end
    end

    always_comb
    begin
        chans   = (cfg.channel_total < 4'(soph_pkg::MAX_CHANNELS)) ?
                  cfg.channel_total : 4'(soph_pkg::MAX_CHANNELS);
        slot_ok = 4'(item.channel_slot) < chans;
        code_ok = item.channel_code[soph_pkg::CHANNEL_ID_WIDTH-1:0] ==
                  cfg.channel_id_table[8*item.channel_slot +: soph_pkg::CHANNEL_ID_WIDTH];
    end

    always_comb
    begin
        if (conflict)
        begin
            status = soph_pkg::ST_ROUTE;
        end
        else if (!cfg.kt_axis_enabled && !cfg.mt_axis_enabled)
        begin
            status = soph_pkg::ST_NO_AXIS;
        end
        else if (item.kt_present != cfg.kt_axis_enabled ||
                 item.mt_present != cfg.mt_axis_enabled)
        begin
            status = soph_pkg::ST_PRESENCE;
        end
        else if (!in_range)
        begin
            status = soph_pkg::ST_RANGE;
        end
        else if (!ident_ok)
        begin
            status = soph_pkg::ST_IDENTITY;
        end
        else if (!slot_ok || !code_ok)
        begin
            status = soph_pkg::ST_CHANNEL;
        end
        else
        begin
            status = soph_pkg::ST_OK;
        end
    end

endmodule
